### sv/atcl_pkg.sv
// Shared types and constants of the AT command line classifier.
package atcl_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int CODE_W = 4;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
  localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_V     = 8'h56;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;

  typedef enum logic [CODE_W-1:0] {
    RC_NO_LF, RC_NO_AT, RC_PING, RC_NO_PLUS, RC_NO_DEVICE,
    RC_E_GET, RC_E_SET, RC_C_GET, RC_C_SET, RC_N_GET, RC_N_SET,
    RC_S_GET, RC_S_SET, RC_VER, RC_RST, RC_UNKNOWN
  } result_code_t;

  // Line state after the current byte, positions already cut to the output width.
  typedef struct packed {
    logic              line_ended;
    logic              at_seen;
    logic [BYTE_W-1:0] byte_after_t;
    logic              plus_set;
    logic [POS_W-1:0]  plus_pos;
    logic [BYTE_W-1:0] device_code;
    logic              equal_set;
    logic [POS_W-1:0]  equal_pos;
    logic              quest_set;
    logic [POS_W-1:0]  quest_pos;
    logic [POS_W-1:0]  lf_pos;
  } line_state_t;

  typedef struct packed {
    result_code_t      code;
    logic [BYTE_W-1:0] device_letter;
    logic [POS_W-1:0]  plus_pos;
    logic [POS_W-1:0]  equal_pos;
    logic [POS_W-1:0]  question_pos;
    logic [POS_W-1:0]  linefeed_pos;
  } result_t;

endpackage

### sv/atcl_in_if.sv
// Request channel carrying line bytes into the classifier.
interface atcl_in_if;
  logic                          valid;
  logic                          ready;
  logic [atcl_pkg::BYTE_W-1:0]   byte_value;
  logic                          end_of_data;

  modport source (output valid, output byte_value, output end_of_data, input ready);
  modport sink   (input valid, input byte_value, input end_of_data, output ready);
endinterface

### sv/atcl_out_if.sv
// Result channel carrying one classification per line.
interface atcl_out_if;
  logic                          valid;
  logic                          ready;
  logic [atcl_pkg::CODE_W-1:0]   result_code;
  logic [atcl_pkg::BYTE_W-1:0]   device_letter;
  logic [atcl_pkg::POS_W-1:0]    plus_position;
  logic [atcl_pkg::POS_W-1:0]    equal_position;
  logic [atcl_pkg::POS_W-1:0]    question_position;
  logic [atcl_pkg::POS_W-1:0]    linefeed_position;

  modport source (output valid, output result_code, output device_letter,
                  output plus_position, output equal_position,
                  output question_position, output linefeed_position, input ready);
  modport sink   (input valid, input result_code, input device_letter,
                  input plus_position, input equal_position,
                  input question_position, input linefeed_position, output ready);
endinterface

### sv/atcl_scanner.sv
// Per-byte line scanner: position and flag registers updated by each byte.
module atcl_scanner #(
  parameter int BUFFER_BYTES = atcl_pkg::BUFFER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take_i,
  input  logic                        last_i,
  input  logic [atcl_pkg::BYTE_W-1:0] byte_i,
  output atcl_pkg::line_state_t       line_o
);

  localparam int IDX_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int EXT_W = IDX_W + atcl_pkg::POS_W;

  logic [CNT_W-1:0]            byte_index_r, byte_index_nxt;
  logic                        line_ended_r, line_ended_nxt;
  logic [IDX_W-1:0]            lf_index_r, lf_index_nxt;
  logic                        prev_a_r, prev_a_nxt;
  logic                        at_seen_r, at_seen_nxt;
  logic [IDX_W-1:0]            last_t_r, last_t_nxt;
  logic [atcl_pkg::BYTE_W-1:0] after_t_r, after_t_nxt;
  logic [IDX_W-1:0]            plus_r, plus_nxt;
  logic [atcl_pkg::BYTE_W-1:0] device_r, device_nxt;
  logic [IDX_W-1:0]            equal_r, equal_nxt;
  logic [IDX_W-1:0]            quest_any_r, quest_any_nxt;
  logic [IDX_W-1:0]            quest_eq_r, quest_eq_nxt;
  logic [IDX_W-1:0]            idx;
  logic                        in_range;

  function automatic logic [atcl_pkg::POS_W-1:0] to_pos(input logic [IDX_W-1:0] p);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(p);
    return ext[atcl_pkg::POS_W-1:0];
  endfunction

  assign idx      = byte_index_r[IDX_W-1:0];
  assign in_range = byte_index_r < CNT_W'(BUFFER_BYTES);

  always_comb begin
    byte_index_nxt = byte_index_r;
    line_ended_nxt = line_ended_r;
    lf_index_nxt   = lf_index_r;
    prev_a_nxt     = prev_a_r;
    at_seen_nxt    = at_seen_r;
    last_t_nxt     = last_t_r;
    after_t_nxt    = after_t_r;
    plus_nxt       = plus_r;
    device_nxt     = device_r;
    equal_nxt      = equal_r;
    quest_any_nxt  = quest_any_r;
    quest_eq_nxt   = quest_eq_r;
    if (!line_ended_r && in_range) begin
      byte_index_nxt = byte_index_r + 1'b1;
      if (idx != '0 && last_t_r == idx - 1'b1) begin
        after_t_nxt = byte_i;
      end
      if (idx != '0 && byte_i == atcl_pkg::CH_LF) begin
        line_ended_nxt = 1'b1;
        lf_index_nxt   = idx;
        prev_a_nxt     = 1'b0;
      end else begin
        if (byte_i == atcl_pkg::CH_T) begin
          if (prev_a_r) begin
            at_seen_nxt = 1'b1;
          end
          last_t_nxt   = idx;
          plus_nxt     = '0;
          device_nxt   = '0;
          equal_nxt    = '0;
          quest_eq_nxt = quest_any_r;
        end else if (byte_i == atcl_pkg::CH_PLUS) begin
          plus_nxt     = idx;
          device_nxt   = '0;
          equal_nxt    = '0;
          quest_eq_nxt = quest_any_r;
        end else if (byte_i == atcl_pkg::CH_EQUAL) begin
          if (plus_r != '0) begin
            equal_nxt    = idx;
            quest_eq_nxt = '0;
          end
        end else if (byte_i == atcl_pkg::CH_QUEST) begin
          quest_any_nxt = idx;
          quest_eq_nxt  = idx;
        end else if (byte_i >= atcl_pkg::CH_A && byte_i <= atcl_pkg::CH_Z) begin
          if (plus_r != '0 && device_r == '0) begin
            device_nxt = byte_i;
          end
        end
        prev_a_nxt = (byte_i == atcl_pkg::CH_A);
      end
    end
  end

  always_comb begin
    line_o.line_ended   = line_ended_nxt;
    line_o.at_seen      = at_seen_nxt;
    line_o.byte_after_t = after_t_nxt;
    line_o.plus_set     = (plus_nxt != '0);
    line_o.plus_pos     = to_pos(plus_nxt);
    line_o.device_code  = device_nxt;
    line_o.equal_set    = (equal_nxt != '0);
    line_o.equal_pos    = to_pos(equal_nxt);
    line_o.quest_set    = (quest_eq_nxt != '0);
    line_o.quest_pos    = to_pos(quest_eq_nxt);
    line_o.lf_pos       = to_pos(lf_index_nxt);
  end

  // A line's last byte returns everything to the reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (take_i && last_i)) begin
      byte_index_r <= '0;
      line_ended_r <= 1'b0;
      lf_index_r   <= '0;
      prev_a_r     <= 1'b0;
      at_seen_r    <= 1'b0;
      last_t_r     <= '0;
      after_t_r    <= '0;
      plus_r       <= '0;
      device_r     <= '0;
      equal_r      <= '0;
      quest_any_r  <= '0;
      quest_eq_r   <= '0;
    end else if (take_i) begin
      byte_index_r <= byte_index_nxt;
      line_ended_r <= line_ended_nxt;
      lf_index_r   <= lf_index_nxt;
      prev_a_r     <= prev_a_nxt;
      at_seen_r    <= at_seen_nxt;
      last_t_r     <= last_t_nxt;
      after_t_r    <= after_t_nxt;
      plus_r       <= plus_nxt;
      device_r     <= device_nxt;
      equal_r      <= equal_nxt;
      quest_any_r  <= quest_any_nxt;
      quest_eq_r   <= quest_eq_nxt;
    end
  end

endmodule

### sv/atcl_classify.sv
// Result decode from the line state after the last byte.
module atcl_classify (
  input  atcl_pkg::line_state_t line_i,
  output atcl_pkg::result_t     res_o
);

  logic is_set;

  assign is_set = line_i.equal_set && !line_i.quest_set;

  always_comb begin
    res_o = '0;
    res_o.code = atcl_pkg::RC_NO_LF;
    if (line_i.line_ended) begin
      res_o.linefeed_pos = line_i.lf_pos;
      if (!line_i.at_seen) begin
        res_o.code = atcl_pkg::RC_NO_AT;
      end else if (line_i.byte_after_t == atcl_pkg::CH_LF ||
                   line_i.byte_after_t == atcl_pkg::CH_QUEST) begin
        res_o.code = atcl_pkg::RC_PING;
      end else if (!line_i.plus_set) begin
        res_o.code = atcl_pkg::RC_NO_PLUS;
      end else if (line_i.device_code == '0) begin
        res_o.code     = atcl_pkg::RC_NO_DEVICE;
        res_o.plus_pos = line_i.plus_pos;
      end else begin
        res_o.plus_pos      = line_i.plus_pos;
        res_o.device_letter = line_i.device_code;
        res_o.equal_pos     = line_i.equal_pos;
        res_o.question_pos  = line_i.quest_pos;
        case (line_i.device_code)
          atcl_pkg::CH_E: res_o.code = is_set ? atcl_pkg::RC_E_SET : atcl_pkg::RC_E_GET;
          atcl_pkg::CH_C: res_o.code = is_set ? atcl_pkg::RC_C_SET : atcl_pkg::RC_C_GET;
          atcl_pkg::CH_N: res_o.code = is_set ? atcl_pkg::RC_N_SET : atcl_pkg::RC_N_GET;
          atcl_pkg::CH_S: res_o.code = is_set ? atcl_pkg::RC_S_SET : atcl_pkg::RC_S_GET;
          atcl_pkg::CH_V: res_o.code = atcl_pkg::RC_VER;
          atcl_pkg::CH_R: res_o.code = atcl_pkg::RC_RST;
          default:        res_o.code = atcl_pkg::RC_UNKNOWN;
        endcase
      end
    end
  end

endmodule

### sv/at_command_line_classifier_unit.sv
// Top level of the AT command line classifier.
// Takes one byte of a command line per cycle and, on the byte flagged end_of_data,
// delivers one result: a command code, the device letter and the positions of the
// '+', '=', '?' and line feed. Bytes after the first BUFFER_BYTES of a line, and
// bytes after the terminating line feed, are ignored; every end_of_data byte ends
// its line, and the next byte starts a fresh one. A byte request is registered in
// the s1 stage and scanned against the line state when it leaves that stage; if it
// ends the line, its result is written to the output register in that same cycle.
// Throughput is one byte per cycle, set by the update of the scanner state registers
// on each taken byte; input is held only while a line's last byte waits for a
// finished result that has not yet been taken.
module at_command_line_classifier_unit #(
  parameter int BUFFER_BYTES = atcl_pkg::BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  atcl_in_if.sink    in_ch,
  atcl_out_if.source out_ch
);

  logic                        s1_valid_r;
  logic [atcl_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_eod_r;
  logic                        out_valid_r;
  atcl_pkg::result_t           out_res_r;
  atcl_pkg::line_state_t       line_state;
  atcl_pkg::result_t           res;
  logic                        out_free;
  logic                        s1_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_eod_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_value;
      s1_eod_r  <= in_ch.end_of_data;
    end
  end

  atcl_scanner #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_scanner (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (s1_fire),
    .last_i (s1_eod_r),
    .byte_i (s1_byte_r),
    .line_o (line_state)
  );

  atcl_classify u_classify (
    .line_i (line_state),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_eod_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_eod_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_code       = out_res_r.code;
  assign out_ch.device_letter     = out_res_r.device_letter;
  assign out_ch.plus_position     = out_res_r.plus_pos;
  assign out_ch.equal_position    = out_res_r.equal_pos;
  assign out_ch.question_position = out_res_r.question_pos;
  assign out_ch.linefeed_position = out_res_r.linefeed_pos;

`ifndef SYNTH
  a_no_lf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.code == atcl_pkg::RC_NO_LF |->
      out_res_r.linefeed_pos == '0 && out_res_r.plus_pos == '0 &&
      out_res_r.device_letter == '0)
    else $error("no-line-feed result carries nonzero fields");

  a_device_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.code >= atcl_pkg::RC_E_GET |->
      out_res_r.device_letter != '0)
    else $error("device code without device letter");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_eod_r |=> out_valid_r)
    else $error("end of line request produced no result");
`endif

endmodule

### dv/tb.sv
// Testbench for the AT command line classifier: directed and random lines, bit-exact scoreboard.
`timescale 1ns / 100ps

import atcl_pkg::*;

class line_classifier_sb;
  bit [7:0]        byte_cnt;
  bit              lf_seen;
  bit [POS_W-1:0]  lf_pos;
  bit              prev_a;
  bit              at_found;
  bit [POS_W-1:0]  t_pos;
  bit [BYTE_W-1:0] after_t;
  bit [POS_W-1:0]  plus_pos;
  bit [BYTE_W-1:0] dev;
  bit [POS_W-1:0]  eq_pos;
  bit [POS_W-1:0]  q_any;
  bit [POS_W-1:0]  q_after_eq;
  result_t         expected_classes[$];
  int              failures;

  function new();
    clear_line();
    failures = 0;
  endfunction

  function void clear_line();
    byte_cnt = 0;
    lf_seen = 0;
    lf_pos = 0;
    prev_a = 0;
    at_found = 0;
    t_pos = 0;
    after_t = 0;
    plus_pos = 0;
    dev = 0;
    eq_pos = 0;
    q_any = 0;
    q_after_eq = 0;
  endfunction

  function int pending();
    return expected_classes.size();
  endfunction

  function void scan_byte(logic [BYTE_W-1:0] b);
    bit [POS_W-1:0] idx;
    if (lf_seen || byte_cnt >= BUFFER_BYTES_DEF) return;
    idx = byte_cnt[POS_W-1:0];
    byte_cnt++;
    if (idx != 0 && t_pos == idx - 1'b1) after_t = b;
    if (idx != 0 && b == CH_LF) begin
      lf_seen = 1;
      lf_pos = idx;
      prev_a = 0;
      return;
    end
    if (b == CH_T) begin
      if (prev_a) at_found = 1;
      t_pos = idx;
      plus_pos = 0;
      dev = 0;
      eq_pos = 0;
      q_after_eq = q_any;
    end else if (b == CH_PLUS) begin
      plus_pos = idx;
      dev = 0;
      eq_pos = 0;
      q_after_eq = q_any;
    end else if (b == CH_EQUAL) begin
      if (plus_pos != 0) begin
        eq_pos = idx;
        q_after_eq = 0;
      end
    end else if (b == CH_QUEST) begin
      q_any = idx;
      q_after_eq = idx;
    end else if (b >= CH_A && b <= CH_Z) begin
      if (plus_pos != 0 && dev == 0) dev = b;
    end
    prev_a = (b == CH_A);
  endfunction

  function result_code_t command_code(bit [BYTE_W-1:0] letter, bit is_set);
    case (letter)
      CH_E: return is_set ? RC_E_SET : RC_E_GET;
      CH_C: return is_set ? RC_C_SET : RC_C_GET;
      CH_N: return is_set ? RC_N_SET : RC_N_GET;
      CH_S: return is_set ? RC_S_SET : RC_S_GET;
      CH_V: return RC_VER;
      CH_R: return RC_RST;
      default: return RC_UNKNOWN;
    endcase
  endfunction

  function void take_request(logic [BYTE_W-1:0] b, logic eod);
    result_t want;
    scan_byte(b);
    if (!eod) return;
    want = '0;
    want.code = RC_NO_LF;
    if (lf_seen) begin
      want.linefeed_pos = lf_pos;
      if (!at_found) want.code = RC_NO_AT;
      else if (after_t == CH_LF || after_t == CH_QUEST) want.code = RC_PING;
      else if (plus_pos == 0) want.code = RC_NO_PLUS;
      else if (dev == 0) begin
        want.code = RC_NO_DEVICE;
        want.plus_pos = plus_pos;
      end else begin
        want.plus_pos = plus_pos;
        want.device_letter = dev;
        want.equal_pos = eq_pos;
        want.question_pos = q_after_eq;
        want.code = command_code(dev, eq_pos != 0 && q_after_eq == 0);
      end
    end
    expected_classes.push_back(want);
    clear_line();
  endfunction

  function void check_classification(result_t got);
    result_t want;
    if (expected_classes.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: code=%0d dev=%02h", got.code, got.device_letter);
      return;
    end
    want = expected_classes.pop_front();
    if (got.code !== want.code || got.device_letter !== want.device_letter ||
        got.plus_pos !== want.plus_pos || got.equal_pos !== want.equal_pos ||
        got.question_pos !== want.question_pos ||
        got.linefeed_pos !== want.linefeed_pos) begin
      failures++;
      if (failures <= 10)
        $display("mismatch at %0t: exp code=%0d dev=%02h +%0d =%0d ?%0d lf%0d | got code=%0d dev=%02h +%0d =%0d ?%0d lf%0d",
                 $time, want.code, want.device_letter, want.plus_pos, want.equal_pos,
                 want.question_pos, want.linefeed_pos, got.code, got.device_letter,
                 got.plus_pos, got.equal_pos, got.question_pos, got.linefeed_pos);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 850;

  logic clk;
  logic rst_n;

  atcl_in_if  in_ch();
  atcl_out_if out_ch();

  at_command_line_classifier_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  line_classifier_sb classifier;
  logic [BYTE_W-1:0] line_q[$];
  int burst_left;
  int bytes_sent;
  int cycles;
  logic [7:0]  rx_tick;
  int          rx_mode;
  logic [15:0] rx_pattern;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        classifier.check_classification({out_ch.result_code, out_ch.device_letter,
                                          out_ch.plus_position, out_ch.equal_position,
                                          out_ch.question_position,
                                          out_ch.linefeed_position});
      if (in_ch.valid && in_ch.ready)
        classifier.take_request(in_ch.byte_value, in_ch.end_of_data);
    end
  end

  // receiver backpressure, mode re-drawn whenever rx_tick[6:0] is zero
  always @(negedge clk) begin
    if (rx_tick[6:0] == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_pattern = $urandom;
    end
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= rx_pattern[rx_tick[3:0]];
      default: out_ch.ready <= (rx_tick[2:0] == 0);
    endcase
    rx_tick = rx_tick + 1;
  end

  function automatic logic [BYTE_W-1:0] filler_char();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                : 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [BYTE_W-1:0] syntax_char();
    case ($urandom_range(0, 11))
      0: return CH_A;
      1: return CH_T;
      2: return CH_PLUS;
      3: return CH_EQUAL;
      4: return CH_QUEST;
      5: return CH_E;
      6: return CH_C;
      7: return CH_N;
      8: return CH_S;
      9: return CH_LF;
      10: return 8'($urandom_range(CH_A, CH_Z));
      default: return filler_char();
    endcase
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void build_command();
    string known;
    known = "ECNSVR";
    repeat ($urandom_range(0, 2)) line_q.push_back(filler_char());
    push_str("AT");
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) push_str("?");
      line_q.push_back(CH_LF);
    end else begin
      repeat ($urandom_range(0, 2)) line_q.push_back(filler_char());
      push_str("+");
      if ($urandom_range(0, 5) == 0) line_q.push_back(filler_char());
      if ($urandom_range(0, 3) == 0) line_q.push_back(syntax_char());
      case ($urandom_range(0, 9))
        0: ;
        1, 2: line_q.push_back(8'($urandom_range(CH_A, CH_Z)));
        default: line_q.push_back(known[$urandom_range(0, 5)]);
      endcase
      repeat ($urandom_range(0, 3)) line_q.push_back(filler_char());
      if ($urandom_range(0, 1)) begin
        push_str("=");
        repeat ($urandom_range(0, 4)) line_q.push_back(filler_char());
      end
      if ($urandom_range(0, 2) == 0) push_str("?");
      if ($urandom_range(0, 4) == 0) line_q.push_back(syntax_char());
      line_q.push_back(CH_LF);
    end
    repeat ($urandom_range(0, 2)) line_q.push_back(8'($urandom));
  endfunction

  function automatic void build_random_line();
    int unsigned kind;
    int unsigned k;
    line_q.delete();
    kind = $urandom_range(0, 15);
    if (kind <= 8) begin
      build_command();
    end else if (kind <= 10) begin
      build_command();
      k = $urandom_range(0, line_q.size() - 1);
      if ($urandom_range(0, 1) && line_q.size() > 1) line_q.delete(k);
      else line_q[k] = 8'($urandom);
    end else if (kind == 11) begin
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom));
    end else if (kind <= 14) begin
      repeat ($urandom_range(2, 16)) line_q.push_back(syntax_char());
      if ($urandom_range(0, 1)) line_q.push_back(CH_LF);
    end else begin
      repeat ($urandom_range(54, 70)) line_q.push_back(filler_char());
      push_str("AT+S=1\n");
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.byte_value  <= b;
    in_ch.end_of_data <= eod;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++)
      send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (classifier.pending() != 0) @(negedge clk);
  endtask

  initial begin
    bit drained_mid;
    classifier = new();
    clk = 0;
    rst_n = 0;
    cycles = 0;
    burst_left = 0;
    bytes_sent = 0;
    drained_mid = 0;
    rx_tick = 0;
    rx_mode = 0;
    rx_pattern = 16'hFFFF;
    in_ch.valid = 0;
    in_ch.byte_value = 0;
    in_ch.end_of_data = 0;
    out_ch.ready = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: lone line feed at index zero, missing line feed, ping, no device,
    // set, get on version, byte extremes without "AT"
    line_q.delete(); line_q.push_back(CH_LF); send_line();
    line_q.delete(); push_str("AT"); send_line();
    line_q.delete(); push_str("AT\n"); send_line();
    line_q.delete(); push_str("AT+\n"); send_line();
    line_q.delete(); push_str("AT+E=1\n"); send_line();
    line_q.delete(); push_str("AT+V?\n"); send_line();
    line_q.delete(); line_q = {8'h00, 8'hFF, CH_LF}; send_line();
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      build_random_line();
      send_line();
      if (!drained_mid && bytes_sent > BYTE_TARGET / 2) begin
        drained_mid = 1;
        drain_results();
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (classifier.failures == 0 && classifier.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
